/* rtl/bpfa_pkg.sv */
// ----------------------------------------------------------------------------
// bpfa_pkg: shared types and constants of the bitmap page-frame allocator
// Sizes of the used-page map, request and response item layouts, status
// codes and the controller/datapath command and status bundles.
// ----------------------------------------------------------------------------
package bpfa_pkg;

   // map geometry
   localparam int MAX_PAGES  = 4096;
   localparam int PAGE_SHIFT = 12;
   localparam int WORD_BITS  = 64;
   localparam int BIT_W      = $clog2(WORD_BITS);
   localparam int MAP_WORDS  = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
   localparam int PAGE_IW    = $clog2(MAX_PAGES);
   localparam int WORD_AW    = PAGE_IW - BIT_W;
   localparam int LIMIT_W    = PAGE_IW + 1;
   localparam int SCAN_W     = WORD_AW + 1;

   // field widths
   localparam int COUNT_W    = 13;
   localparam int PADDR_W    = 32;
   localparam int ADDR_W     = 24;
   localparam int IDX_W      = PADDR_W - PAGE_SHIFT;

   localparam logic [COUNT_W-1:0] PAGE_COUNT_RESET = COUNT_W'(4096);

   // request kinds
   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE  = 1'b1;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_OOM   = 2'd1,
      ST_RANGE = 2'd2
   } status_type;

   typedef struct packed {
      logic               req_type;
      logic [PADDR_W-1:0] frame_addr;
   } req_item_type;

   typedef struct packed {
      status_type        status;
      logic [ADDR_W-1:0] page_addr;
   } rsp_item_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ALLOC,
      S_FREE_RD,
      S_FREE_WR
   } fsm_state_type;

   // controller -> datapath
   typedef struct packed {
      logic       load;
      logic       scan_en;
      logic       free_rd;
      logic       alloc_wr;
      logic       free_wr;
      logic       resp_en;
      status_type resp_status;
   } dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic hit;
      logic scan_more;
      logic range_err;
   } dp_stat_type;

endpackage

/* rtl/bpfa_ram.sv */
// ----------------------------------------------------------------------------
// bpfa_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module bpfa_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/bpfa_ctrl.sv */
// ----------------------------------------------------------------------------
// bpfa_ctrl: request sequencer of the page-frame allocator
// Steps an allocate through the word scan, a free through read and write
// back, and issues the response.
// ----------------------------------------------------------------------------
module bpfa_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  req_free,
   input  bpfa_pkg::dp_stat_type stat,
   output bpfa_pkg::dp_cmd_type  cmd,
   output logic                  busy
);
   import bpfa_pkg::*;

   fsm_state_type state_ff, state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = (req_free == REQ_FREE) ? S_FREE_RD : S_ALLOC;
            end
         end
         S_ALLOC: begin
            if (stat.hit || !stat.scan_more) begin
               state_in = S_IDLE;
            end
         end
         S_FREE_RD: begin
            state_in = stat.range_err ? S_IDLE : S_FREE_WR;
         end
         S_FREE_WR: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      cmd             = '0;
      cmd.resp_status = ST_DONE;
      busy            = 1'b1;
      case (state_ff)
         S_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         S_ALLOC: begin
            cmd.scan_en = 1'b1;
            if (stat.hit) begin
               cmd.alloc_wr = 1'b1;
               cmd.resp_en  = 1'b1;
            end else if (!stat.scan_more) begin
               cmd.resp_en     = 1'b1;
               cmd.resp_status = ST_OOM;
            end
         end
         S_FREE_RD: begin
            if (stat.range_err) begin
               cmd.resp_en     = 1'b1;
               cmd.resp_status = ST_RANGE;
            end else begin
               cmd.free_rd = 1'b1;
            end
         end
         S_FREE_WR: begin
            cmd.free_wr = 1'b1;
            cmd.resp_en = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef NO_ASSERTIONS
   // a response always ends the request
   a_resp_ends: assert property (@(posedge clock) disable iff (reset)
      cmd.resp_en |=> (state_ff == S_IDLE))
      else $error("response issued but sequencer did not return to idle");

   // never write the map for both request kinds at once
   a_one_write: assert property (@(posedge clock) disable iff (reset)
      !(cmd.alloc_wr && cmd.free_wr))
      else $error("allocate and free write in the same cycle");
`endif

endmodule

/* rtl/bpfa_dp.sv */
// ----------------------------------------------------------------------------
// bpfa_dp: datapath of the page-frame allocator
// Holds the page-count register, the captured request, the used-page map
// with per-word valid bits, the scan pipeline and the response register.
// ----------------------------------------------------------------------------
module bpfa_dp (
   input  logic                             clock,
   input  logic                             reset,
   input  bpfa_pkg::req_item_type           req_data,
   input  logic                             csr_wr,
   input  logic [bpfa_pkg::COUNT_W-1:0]     csr_data,
   input  bpfa_pkg::dp_cmd_type             cmd,
   output bpfa_pkg::dp_stat_type            stat,
   output logic                             rsp_valid,
   output bpfa_pkg::rsp_item_type           rsp_data
);
   import bpfa_pkg::*;

   logic [COUNT_W-1:0]   page_count_ff;
   req_item_type         req_ff;
   logic [SCAN_W-1:0]    scan_ff, scan_in;
   logic                 chk_valid_ff;
   logic [WORD_AW-1:0]   chk_word_ff;
   logic                 rd_valid_ff;
   logic [MAP_WORDS-1:0] valid_ff;
   logic                 rsp_valid_ff;
   rsp_item_type         rsp_ff;

   logic [LIMIT_W-1:0]   limit;
   logic [SCAN_W-1:0]    words_full;
   logic [SCAN_W-1:0]    words_needed;
   logic [IDX_W-1:0]     free_idx;
   logic [WORD_AW-1:0]   free_word;
   logic [BIT_W-1:0]     free_bit;
   logic                 rd_en;
   logic [WORD_AW-1:0]   rd_addr;
   logic [WORD_BITS-1:0] ram_q;
   logic [WORD_BITS-1:0] word_eff;
   logic [WORD_BITS-1:0] word_mask;
   logic [WORD_BITS-1:0] free_bits;
   logic [WORD_BITS-1:0] first_free;
   logic [BIT_W-1:0]     first_pos;
   logic [PAGE_IW-1:0]   alloc_page;
   logic [ADDR_W-1:0]    alloc_addr;
   logic                 wr_en;
   logic [WORD_AW-1:0]   wr_addr;
   logic [WORD_BITS-1:0] wr_data;

   // effective page count, saturated to the map size
   assign limit = (page_count_ff > COUNT_W'(MAX_PAGES)) ? LIMIT_W'(MAX_PAGES)
                                                        : LIMIT_W'(page_count_ff);
   assign words_full   = SCAN_W'(limit >> BIT_W);
   assign words_needed = SCAN_W'((limit + LIMIT_W'(WORD_BITS - 1)) >> BIT_W);

   // free request decode
   assign free_idx  = req_ff.frame_addr[PADDR_W-1:PAGE_SHIFT];
   assign free_word = free_idx[PAGE_IW-1:BIT_W];
   assign free_bit  = free_idx[BIT_W-1:0];

   // map read port: scan word or the word of the page being freed
   assign rd_en   = (cmd.scan_en && stat.scan_more) || cmd.free_rd;
   assign rd_addr = cmd.free_rd ? free_word : scan_ff[WORD_AW-1:0];

   // a word never written reads as all free
   assign word_eff = rd_valid_ff ? ram_q : '0;

   // pages of the checked word that lie below the limit
   always_comb begin
      if ({1'b0, chk_word_ff} < words_full) begin
         word_mask = '1;
      end else if ({1'b0, chk_word_ff} == words_full) begin
         word_mask = (WORD_BITS'(1) << limit[BIT_W-1:0]) - WORD_BITS'(1);
      end else begin
         word_mask = '0;
      end
   end

   // lowest free page in the checked word
   assign free_bits  = ~word_eff & word_mask;
   assign first_free = free_bits & (~free_bits + WORD_BITS'(1));

   always_comb begin
      for (int b = 0; b < BIT_W; b++) begin
         first_pos[b] = 1'b0;
         for (int i = 0; i < WORD_BITS; i++) begin
            if (i[b]) begin
               first_pos[b] = first_pos[b] | first_free[i];
            end
         end
      end
   end

   assign alloc_page = {chk_word_ff, first_pos};
   assign alloc_addr = ADDR_W'({alloc_page, {PAGE_SHIFT{1'b0}}});

   // status to the sequencer
   assign stat.hit       = chk_valid_ff && (free_bits != '0);
   assign stat.scan_more = scan_ff < words_needed;
   assign stat.range_err = free_idx >= IDX_W'(limit);

   // map write port: set the allocated bit or clear the freed one
   assign wr_en   = cmd.alloc_wr || cmd.free_wr;
   assign wr_addr = cmd.alloc_wr ? chk_word_ff : free_word;
   assign wr_data = cmd.alloc_wr ? (word_eff | first_free)
                                 : (word_eff & ~(WORD_BITS'(1) << free_bit));

   bpfa_ram #(
      .WIDTH(WORD_BITS),
      .DEPTH(MAP_WORDS)
   ) u_map (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   // scan counter: restart on load, advance each scan cycle
   always_comb begin
      scan_in = scan_ff;
      if (cmd.load) begin
         scan_in = '0;
      end else if (cmd.scan_en && stat.scan_more) begin
         scan_in = scan_ff + SCAN_W'(1);
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         page_count_ff <= PAGE_COUNT_RESET;
         scan_ff       <= '0;
         chk_valid_ff  <= 1'b0;
         valid_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr) begin
            page_count_ff <= csr_data;
         end
         scan_ff      <= scan_in;
         chk_valid_ff <= !cmd.load && cmd.scan_en && stat.scan_more;
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         rsp_valid_ff <= cmd.resp_en;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
      end
      if (cmd.scan_en && stat.scan_more) begin
         chk_word_ff <= scan_ff[WORD_AW-1:0];
      end
      if (rd_en) begin
         rd_valid_ff <= valid_ff[rd_addr];
      end
      if (cmd.resp_en) begin
         rsp_ff.status    <= cmd.resp_status;
         rsp_ff.page_addr <= cmd.alloc_wr ? alloc_addr : '0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef NO_ASSERTIONS
   // an allocation only lands in a word below the page limit
   a_alloc_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.alloc_wr |-> ({1'b0, chk_word_ff} < words_needed))
      else $error("allocation outside the managed pages");

   // a nonzero address only comes with a completed request
   a_addr_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_ff.page_addr != '0)) |-> (rsp_ff.status == ST_DONE))
      else $error("page address returned with an error status");
`endif

endmodule

/* rtl/bitmap_page_frame_allocator_unit.sv */
// ----------------------------------------------------------------------------
// bitmap_page_frame_allocator_unit: first-fit page-frame allocator
// Keeps one used bit per page, hands out the lowest free page on allocate
// and clears a page's bit on free.
//
//   channel  handshake              payload
//   req      start / busy           req_data  (req_type, frame_addr)
//   rsp      rsp_valid strobe       rsp_data  (status, page_addr)
//   csr      csr_valid / csr_ready  csr_data  (page_count)
//
// Allocate: the map is read one 64-page word per cycle, each word checked
// the cycle after its read; the strobe is registered from the check of the
// word holding the page found, or of the last word below the page count when
// out of memory. Free: read, write back, strobe; out of range, strobe only.
// busy drops in the strobe cycle, so the next request may transfer there.
// Reset clears the map at once through per-word valid bits; no sweep.
// ----------------------------------------------------------------------------
module bitmap_page_frame_allocator_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  bpfa_pkg::req_item_type       req_data,
   output logic                         rsp_valid,
   output bpfa_pkg::rsp_item_type       rsp_data,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [bpfa_pkg::COUNT_W-1:0] csr_data
);
   import bpfa_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;
   logic        ctrl_busy;

   // take configuration only between requests
   assign csr_ready = !ctrl_busy;
   assign busy      = ctrl_busy;

   bpfa_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_free (req_data.req_type),
      .stat     (stat),
      .cmd      (cmd),
      .busy     (ctrl_busy)
   );

   bpfa_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_wr    (csr_valid && csr_ready),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

`ifndef NO_ASSERTIONS
   // finishing a request always produces its response
   a_fall_resp: assert property (@(posedge clock) disable iff (reset)
      $fell(ctrl_busy) |-> rsp_valid)
      else $error("request finished without a response");

   // a response only shows while idle
   a_resp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !ctrl_busy)
      else $error("response strobe while busy");
`endif

endmodule
